// File: design/pipm_pkg.sv
// Shared constants and types for the perspective inverse pixel map.
package pipm_pkg;

	localparam int COEF_W  = 48;
	localparam int COL_W   = 12;
	localparam int ROW_W   = 11;
	localparam int CFG_A_W = 3;

	localparam int DEF_VIRT_WIDTH  = 4096;
	localparam int DEF_VIRT_HEIGHT = 2048;
	localparam int DEF_SRC_WIDTH   = 4096;
	localparam int DEF_SRC_HEIGHT  = 2048;

	// product of a coefficient and a zero-extended 12-bit coordinate
	localparam int PROD_W = COEF_W + COL_W + 1;
	// sum of three terms
	localparam int SUM_W  = PROD_W + 2;
	// magnitude of a sum
	localparam int MAG_W  = SUM_W;

	localparam logic signed [COEF_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;

	typedef enum logic [CFG_A_W-1:0] {
		REG_NUM_U_BY_U  = 3'd0,
		REG_NUM_U_BY_V  = 3'd1,
		REG_NUM_U_CONST = 3'd2,
		REG_NUM_V_BY_U  = 3'd3,
		REG_NUM_V_BY_V  = 3'd4,
		REG_NUM_V_CONST = 3'd5,
		REG_DEN_BY_U    = 3'd6,
		REG_DEN_BY_V    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic bad;
		logic neg_u;
		logic neg_v;
	} ctl_t;

endpackage

// File: design/perspective_inverse_pixel_map.sv
// Top level of the perspective inverse pixel map.
//
// Input stream s_*: one word per virtual pixel, tdata = virt_col[11:0],
// virt_row[22:12], zero padding. Output stream m_*: one word per input word,
// in order, tdata = src_col[11:0], src_row[22:12], tuser = in_range.
// Coefficients are written through cfg_we/cfg_addr/cfg_data (index 0..7,
// signed Q16.32), by the user only while the block is idle (not enforced).
// Pipeline stages: multiply, sum, magnitude, one divider overflow stage plus
// one stage per quotient bit, output register. Throughput is one word per
// cycle while the receiver is ready.
// Reset loads the identity homography and empties the pipeline.
// When an output word is waiting and the receiver is not ready the whole
// pipeline holds, empty stages included; s_tready drops only in that
// case.
module perspective_inverse_pixel_map #(
	parameter int VIRT_WIDTH  = pipm_pkg::DEF_VIRT_WIDTH,
	parameter int VIRT_HEIGHT = pipm_pkg::DEF_VIRT_HEIGHT,
	parameter int SRC_WIDTH   = pipm_pkg::DEF_SRC_WIDTH,
	parameter int SRC_HEIGHT  = pipm_pkg::DEF_SRC_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pipm_pkg::CFG_A_W-1:0]   cfg_addr,
	input  logic [pipm_pkg::COEF_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,  // virt_col, virt_row, pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,  // src_col, src_row, pad
	output logic                           m_tuser   // in_range
);
	import pipm_pkg::*;

	localparam int SMAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int QB   = $clog2(SMAX);
	localparam int DLAT = QB + 1;
	localparam logic [13:0] VW = 14'(VIRT_WIDTH);
	localparam logic [13:0] VH = 14'(VIRT_HEIGHT);
	localparam logic [QB:0] SW_MAX = (QB+1)'(SRC_WIDTH - 1);
	localparam logic [QB:0] SH_MAX = (QB+1)'(SRC_HEIGHT - 1);

	logic signed [COEF_W-1:0] coef_q [0:7];
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_NUM_U_BY_U]  <= ONE_Q32;
			coef_q[REG_NUM_U_BY_V]  <= '0;
			coef_q[REG_NUM_U_CONST] <= '0;
			coef_q[REG_NUM_V_BY_U]  <= '0;
			coef_q[REG_NUM_V_BY_V]  <= ONE_Q32;
			coef_q[REG_NUM_V_CONST] <= '0;
			coef_q[REG_DEN_BY_U]    <= '0;
			coef_q[REG_DEN_BY_V]    <= '0;
		end else if (cfg_we) begin
			coef_q[cfg_addr] <= cfg_data;
		end
	end

	// stage 1: products
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic signed [COL_W:0] col_x, row_x;
	assign col   = s_tdata[COL_W-1:0];
	assign row   = s_tdata[COL_W+ROW_W-1:COL_W];
	assign col_x = signed'({1'b0, col});
	assign row_x = signed'({2'b0, row});

	logic signed [PROD_W-1:0] p_uu_s1, p_uv_s1, p_vu_s1, p_vv_s1, p_du_s1, p_dv_s1;
	ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.bad   <= ({2'b0, col} >= VW) || ({3'b0, row} >= VH);
			ctl_s1.neg_u <= 1'b0;
			ctl_s1.neg_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_uu_s1 <= coef_q[REG_NUM_U_BY_U] * col_x;
			p_uv_s1 <= coef_q[REG_NUM_U_BY_V] * row_x;
			p_vu_s1 <= coef_q[REG_NUM_V_BY_U] * col_x;
			p_vv_s1 <= coef_q[REG_NUM_V_BY_V] * row_x;
			p_du_s1 <= coef_q[REG_DEN_BY_U] * col_x;
			p_dv_s1 <= coef_q[REG_DEN_BY_V] * row_x;
		end
	end

	// stage 2: sums
	logic signed [SUM_W-1:0] nu_s2, nv_s2, d_s2;
	ctl_t ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s2 <= SUM_W'(p_uu_s1) + SUM_W'(p_uv_s1) + SUM_W'(coef_q[REG_NUM_U_CONST]);
			nv_s2 <= SUM_W'(p_vu_s1) + SUM_W'(p_vv_s1) + SUM_W'(coef_q[REG_NUM_V_CONST]);
			d_s2  <= SUM_W'(p_du_s1) + SUM_W'(p_dv_s1) + SUM_W'(ONE_Q32);
		end
	end

	// stage 3: magnitudes and signs
	logic [MAG_W-1:0] nu_m_s3, nv_m_s3, d_m_s3;
	ctl_t ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.bad   <= ctl_s2.bad || (d_s2 == '0);
			ctl_s3.neg_u <= nu_s2[SUM_W-1] ^ d_s2[SUM_W-1];
			ctl_s3.neg_v <= nv_s2[SUM_W-1] ^ d_s2[SUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_m_s3 <= nu_s2[SUM_W-1] ? MAG_W'(-nu_s2) : MAG_W'(nu_s2);
			nv_m_s3 <= nv_s2[SUM_W-1] ? MAG_W'(-nv_s2) : MAG_W'(nv_s2);
			d_m_s3  <= d_s2[SUM_W-1]  ? MAG_W'(-d_s2)  : MAG_W'(d_s2);
		end
	end

	// dividers
	logic [QB-1:0] qu, qv;
	logic ovf_u, ovf_v;

	pipm_div #(.QB(QB)) u_div_col (
		.clk (clk), .en (en), .num (nu_m_s3), .den (d_m_s3), .quo (qu), .ovf (ovf_u)
	);

	pipm_div #(.QB(QB)) u_div_row (
		.clk (clk), .en (en), .num (nv_m_s3), .den (d_m_s3), .quo (qv), .ovf (ovf_v)
	);

	ctl_t ctl_d [0:DLAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DLAT; i++) ctl_d[i] <= '0;
		end else if (en) begin
			ctl_d[0] <= ctl_s3;
			for (int i = 1; i < DLAT; i++) ctl_d[i] <= ctl_d[i-1];
		end
	end

	// output stage
	ctl_t ctl_e;
	logic ok_u, ok_v, ok;
	assign ctl_e = ctl_d[DLAT-1];
	assign ok_u  = !ovf_u && ((qu == '0) || !ctl_e.neg_u) && ({1'b0, qu} <= SW_MAX);
	assign ok_v  = !ovf_v && ((qv == '0) || !ctl_e.neg_v) && ({1'b0, qv} <= SH_MAX);
	assign ok    = ok_u && ok_v && !ctl_e.bad;

	logic             out_valid_q;
	logic [COL_W-1:0] src_col_q;
	logic [ROW_W-1:0] src_row_q;
	logic             in_range_q;

	assign en = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_col_q  <= ok ? COL_W'(qu) : '0;
			src_row_q  <= ok ? ROW_W'(qv) : '0;
			in_range_q <= ok;
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, src_row_q, src_col_q};
	assign m_tuser  = in_range_q;

endmodule

// File: design/pipm_div.sv
// Pipelined unsigned restoring divider with quotient overflow flag.
module pipm_div #(
	parameter int QB = 12
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pipm_pkg::MAG_W-1:0]    num,
	input  logic [pipm_pkg::MAG_W-1:0]    den,
	output logic [QB-1:0]                 quo,
	output logic                          ovf
);
	import pipm_pkg::*;

	localparam int XW = MAG_W + QB;

	logic [MAG_W-1:0] rem_s [0:QB];
	logic [MAG_W-1:0] den_s [0:QB];
	logic [QB-1:0]    quo_s [0:QB];
	logic             ovf_s [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= {{QB{1'b0}}, num} >= ({{QB{1'b0}}, den} << QB);
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_step
		logic [XW-1:0] trial;
		logic          take;
		assign trial = {{QB{1'b0}}, den_s[i-1]} << (QB - i);
		assign take  = {{QB{1'b0}}, rem_s[i-1]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? MAG_W'({{QB{1'b0}}, rem_s[i-1]} - trial) : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				quo_s[i] <= quo_s[i-1] | (take ? (QB'(1) << (QB - i)) : '0);
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// File: design/pipm_chk.sv
// Port checker for the perspective inverse pixel map, with its bind.
module pipm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 24'd0)
		else $error("out-of-range word carries nonzero coordinates");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[23])
		else $error("padding bit set");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled word changed");

endmodule

bind perspective_inverse_pixel_map pipm_chk u_pipm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: verif/tb_perspective_inverse_pixel_map.sv
// Self-checking testbench for the perspective inverse pixel map.
module tb_perspective_inverse_pixel_map;
	timeunit 1ns;
	timeprecision 1ps;

	import pipm_pkg::*;

	localparam int LATENCY = 17;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [10:0] row;
		logic [11:0] col;
	} vpix_t;

	typedef struct packed {
		logic [11:0] col;
		logic [10:0] row;
		logic        ok;
	} spix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_A_W-1:0] cfg_addr = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;

	perspective_inverse_pixel_map dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint coef [8];
	vpix_t pending_pix [$];
	spix_t expected_pix [$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic spix_t map_pixel(vpix_t p);
		spix_t o;
		longint c, r, nu, nv, d, qu, qv;
		o = '0;
		c = p.col;
		r = p.row;
		if (c >= DEF_VIRT_WIDTH || r >= DEF_VIRT_HEIGHT) return o;
		nu = coef[REG_NUM_U_BY_U] * c + coef[REG_NUM_U_BY_V] * r + coef[REG_NUM_U_CONST];
		nv = coef[REG_NUM_V_BY_U] * c + coef[REG_NUM_V_BY_V] * r + coef[REG_NUM_V_CONST];
		d = coef[REG_DEN_BY_U] * c + coef[REG_DEN_BY_V] * r + (64'sd1 <<< 32);
		if (d == 0) return o;
		qu = nu / d;
		qv = nv / d;
		if (qu < 0 || qu > DEF_SRC_WIDTH - 1 || qv < 0 || qv > DEF_SRC_HEIGHT - 1) return o;
		o.col = qu[11:0];
		o.row = qv[10:0];
		o.ok = 1'b1;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: take the next word from the pending queue
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!s_tvalid || s_tready) begin
			if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= {1'b0, pending_pix[0]};
				expected_pix.push_back(map_pixel(pending_pix[0]));
				void'(pending_pix.pop_front());
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		spix_t want;
		if (m_tvalid && m_tready) begin
			if (expected_pix.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 0);
			end else begin
				want = expected_pix.pop_front();
				if (m_tdata[11:0] !== want.col) report_mismatch("src_col", m_tdata[11:0], want.col);
				if (m_tdata[22:12] !== want.row) report_mismatch("src_row", m_tdata[22:12], want.row);
				if (m_tuser !== want.ok) report_mismatch("in_range", m_tuser, want.ok);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_pix.size() == 0 && !s_tvalid);
		wait (expected_pix.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_coef(cfg_reg_t idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val[COEF_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		coef[idx] = val;
	endtask

	task automatic queue_pixel(int c, int r);
		vpix_t p;
		p.col = 12'(c);
		p.row = 11'(r);
		pending_pix.push_back(p);
	endtask

	function automatic longint rand_coef(longint span);
		longint v;
		v = {$urandom, $urandom};
		v = v % span;
		return v;
	endfunction

	task automatic load_homography(longint k[8]);
		for (int i = 0; i < 8; i++) write_coef(cfg_reg_t'(i), k[i]);
	endtask

	localparam longint ONE = 64'sd1 <<< 32;
	localparam longint CMAX = (64'sd1 <<< 47) - 1;
	localparam longint CMIN = -(64'sd1 <<< 47);

	initial begin
		longint k [8];
		coef = '{ONE, 0, 0, 0, ONE, 0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity: corners and interior points
		queue_pixel(0, 0);
		queue_pixel(4095, 2047);
		queue_pixel(4095, 0);
		queue_pixel(0, 2047);
		queue_pixel(2730, 1365);
		queue_pixel(1365, 682);
		drain();

		// zero denominator at c=1, shift out of range, negative results
		k = '{ONE, 0, ONE * 5, 0, ONE, -ONE * 3, -ONE, 0};
		load_homography(k);
		queue_pixel(1, 0);
		queue_pixel(0, 0);
		queue_pixel(0, 2);
		queue_pixel(0, 5);
		queue_pixel(2, 7);
		queue_pixel(3, 9);
		drain();

		// extremes of the coefficients
		k = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN};
		load_homography(k);
		queue_pixel(0, 0);
		queue_pixel(4095, 2047);
		queue_pixel(4095, 0);
		queue_pixel(0, 2047);
		queue_pixel(17, 3);
		drain();

		// random homographies across idling phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			// mostly near-identity mild perspective so many pixels land in range
			k[REG_NUM_U_BY_U]  = ONE / 2 + rand_coef(ONE);
			k[REG_NUM_U_BY_V]  = rand_coef(ONE / 4);
			k[REG_NUM_U_CONST] = rand_coef(ONE * 512);
			k[REG_NUM_V_BY_U]  = rand_coef(ONE / 4);
			k[REG_NUM_V_BY_V]  = ONE / 2 + rand_coef(ONE);
			k[REG_NUM_V_CONST] = rand_coef(ONE * 256);
			k[REG_DEN_BY_U]    = rand_coef(ONE / 8192);
			k[REG_DEN_BY_V]    = rand_coef(ONE / 8192);
			if (ph == 7) for (int i = 0; i < 8; i++) k[i] = rand_coef(CMAX);
			load_homography(k);
			for (int n = 0; n < 50; n++) begin
				if (n == 25) begin
					wait (pending_pix.size() == 0 && !s_tvalid);
					wait (expected_pix.size() == 0);
				end
				queue_pixel($urandom_range(4095), $urandom_range(2047));
			end
			drain();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: perspective_inverse_pixel_map.f
design/pipm_pkg.sv
design/pipm_div.sv
design/perspective_inverse_pixel_map.sv
design/pipm_chk.sv
verif/tb_perspective_inverse_pixel_map.sv
